// ----- rtl/core/aaq_pkg.sv -----
package aaq_pkg;

  localparam int FUNC_W    = 2;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 10;
  localparam int GRAY_W    = 8;
  localparam int STEP_W    = 5;
  localparam int THR_W     = 9;
  localparam int LEVEL_W   = 4;
  localparam int GLYPH_W   = 7;
  localparam int WIDTH_W   = 13;
  localparam int COL_W     = 12;
  localparam int LEVELS    = 15;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

  localparam logic [GRAY_W-1:0] MIN_GRAY_RESET = 8'd255;
  localparam logic [GRAY_W-1:0] MAX_GRAY_RESET = 8'd0;

  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CONVERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  // floor(sum / 3) for sum <= 765, by reciprocal 683 / 2048
  function automatic logic [GRAY_W-1:0] gray_of(input logic [SUM_W-1:0] sum);
    logic [18:0] prod;
    prod = 19'(sum) * 19'd683;
    return prod[18:11];
  endfunction

  // floor(diff / 14) for diff <= 255, by reciprocal 293 / 4096
  function automatic logic [STEP_W-1:0] step_of(input logic [GRAY_W-1:0] diff);
    logic [16:0] prod;
    prod = 17'(diff) * 17'd293;
    return prod[16:12];
  endfunction

  // ramp read in reverse: dark is '@', bright is space
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    unique case (lvl)
      4'd0:    g = 7'h40; // @
      4'd1:    g = 7'h23; // #
      4'd2:    g = 7'h25; // %
      4'd3:    g = 7'h26; // &
      4'd4:    g = 7'h2B; // +
      4'd5:    g = 7'h21; // !
      4'd6:    g = 7'h3A; // :
      4'd7:    g = 7'h2A; // *
      4'd8:    g = 7'h5E; // ^
      4'd9:    g = 7'h7E; // ~
      4'd10:   g = 7'h2D; // -
      4'd11:   g = 7'h2C; // ,
      4'd12:   g = 7'h2E; // .
      4'd13:   g = 7'h60; // `
      default: g = 7'h20; // space
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/aaq_level.sv -----
module aaq_level (
  input  logic [aaq_pkg::GRAY_W-1:0]  gray,
  input  logic [aaq_pkg::GRAY_W-1:0]  lo,
  input  logic [aaq_pkg::STEP_W-1:0]  step_size,
  output logic [aaq_pkg::LEVEL_W-1:0] level,
  output logic [aaq_pkg::GLYPH_W-1:0] glyph
);

  logic [aaq_pkg::THR_W-1:0] thr [aaq_pkg::LEVELS];

  // thresholds are nondecreasing, so the last one reached wins
  always_comb begin
    level = '0;
    for (int k = 0; k < aaq_pkg::LEVELS; k++) begin
      thr[k] = {1'b0, lo} + aaq_pkg::THR_W'(step_size * k);
      if (k > 0 && {1'b0, gray} >= thr[k]) begin
        level = aaq_pkg::LEVEL_W'(k);
      end
    end
  end

  assign glyph = aaq_pkg::glyph_of(level);

endmodule

// ----- rtl/core/ascii_art_quantizer_core.sv -----
// ASCII-art gray quantizer.
// Slave stream: one RGB pixel per transaction, tuser carries the function
// (measure, convert, clear). Measure transactions track min/max gray, clear
// restarts the image state, convert transactions each return one glyph.
// Master stream: tdata carries glyph and level, tuser flags a row start.
// Configuration: cfg_valid/cfg_ready/cfg_data writes image_width; always ready.
// Pipeline: a convert transaction is held in the input register, then its
// glyph and level are loaded into the result register when the pipeline
// advances. Throughput is one pixel per cycle while the output is not stalled;
// min/max, the quantizer step and the column counter update in the result
// stage, so back-to-back measure and convert pixels need no bubble.
// Reset: image_width returns to 640, min 255, max 0, nothing measured,
// column 0; both stream valids drop.
// Stall: while a result waits with m_axis_tready low, the pipeline holds and
// s_axis_tready drops once the input register is also occupied.
module ascii_art_quantizer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aaq_pkg::WIDTH_W-1:0]   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red, green, blue
  input  logic [aaq_pkg::FUNC_W-1:0]    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // zero pad, level, glyph
  output logic [0:0]                    m_axis_tuser   // row_start
);

  logic [aaq_pkg::WIDTH_W-1:0] image_width;

  logic                         in_valid;
  logic [aaq_pkg::FUNC_W-1:0]   in_func;
  logic [aaq_pkg::GRAY_W-1:0]   in_gray;

  logic [aaq_pkg::GRAY_W-1:0]   min_gray;
  logic [aaq_pkg::GRAY_W-1:0]   max_gray;
  logic                         any_measured;
  logic [aaq_pkg::STEP_W-1:0]   step_size;
  logic [aaq_pkg::COL_W-1:0]    column_count;

  logic                         out_valid;
  logic [aaq_pkg::GLYPH_W-1:0]  out_glyph;
  logic [aaq_pkg::LEVEL_W-1:0]  out_level;
  logic                         out_start;

  logic                         advance;
  logic                         proc;
  logic                         s_acc;
  logic [aaq_pkg::SUM_W-1:0]    pix_sum;

  logic [aaq_pkg::GRAY_W-1:0]   lo;
  logic [aaq_pkg::LEVEL_W-1:0]  level;
  logic [aaq_pkg::GLYPH_W-1:0]  glyph;
  logic [aaq_pkg::GRAY_W-1:0]   min_next;
  logic [aaq_pkg::GRAY_W-1:0]   max_next;
  logic [aaq_pkg::WIDTH_W-1:0]  w_eff;
  logic [aaq_pkg::COL_W-1:0]    col_cur;
  logic [aaq_pkg::WIDTH_W-1:0]  col_inc;
  logic [aaq_pkg::COL_W-1:0]    column_count_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= aaq_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      image_width <= cfg_data;
    end
  end

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign proc          = in_valid && advance;

  assign pix_sum = aaq_pkg::SUM_W'(s_axis_tdata[7:0]) + aaq_pkg::SUM_W'(s_axis_tdata[15:8])
                 + aaq_pkg::SUM_W'(s_axis_tdata[23:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_acc) begin
      in_func <= s_axis_tuser;
      in_gray <= aaq_pkg::gray_of(pix_sum);
    end
  end

  assign lo = any_measured ? min_gray : '0;

  aaq_level u_level (
    .gray      (in_gray),
    .lo        (lo),
    .step_size (step_size),
    .level     (level),
    .glyph     (glyph)
  );

  always_comb begin
    if (image_width == '0) begin
      w_eff = aaq_pkg::WIDTH_W'(1);
    end else if (image_width > aaq_pkg::MAX_WIDTH) begin
      w_eff = aaq_pkg::MAX_WIDTH;
    end else begin
      w_eff = image_width;
    end
    col_cur = ({1'b0, column_count} >= w_eff) ? '0 : column_count;
    col_inc = {1'b0, col_cur} + aaq_pkg::WIDTH_W'(1);
    column_count_next = (col_inc >= w_eff) ? '0 : col_inc[aaq_pkg::COL_W-1:0];
    min_next = (in_gray < min_gray) ? in_gray : min_gray;
    max_next = (in_gray > max_gray) ? in_gray : max_gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gray     <= aaq_pkg::MIN_GRAY_RESET;
      max_gray     <= aaq_pkg::MAX_GRAY_RESET;
      any_measured <= 1'b0;
      step_size    <= '0;
      column_count <= '0;
    end else if (proc) begin
      unique case (in_func)
        aaq_pkg::FUNC_MEASURE: begin
          min_gray     <= min_next;
          max_gray     <= max_next;
          any_measured <= 1'b1;
          step_size    <= aaq_pkg::step_of(max_next - min_next);
        end
        aaq_pkg::FUNC_CONVERT: begin
          column_count <= column_count_next;
        end
        aaq_pkg::FUNC_CLEAR: begin
          min_gray     <= aaq_pkg::MIN_GRAY_RESET;
          max_gray     <= aaq_pkg::MAX_GRAY_RESET;
          any_measured <= 1'b0;
          step_size    <= '0;
          column_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && (in_func == aaq_pkg::FUNC_CONVERT);
    end
    if (proc && in_func == aaq_pkg::FUNC_CONVERT) begin
      out_glyph <= glyph;
      out_level <= level;
      out_start <= (col_cur == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_level, out_glyph};
  assign m_axis_tuser  = out_start;

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    any_measured |-> (min_gray <= max_gray))
    else $error("min gray above max gray after a measurement");

  a_step_tracks: assert property (@(posedge clk) disable iff (rst)
    step_size == (any_measured ? aaq_pkg::step_of(max_gray - min_gray) : '0))
    else $error("quantizer step out of step with min/max");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (proc && in_func == aaq_pkg::FUNC_CLEAR) |=>
      (min_gray == aaq_pkg::MIN_GRAY_RESET && max_gray == aaq_pkg::MAX_GRAY_RESET &&
       !any_measured && column_count == '0))
    else $error("clear did not restore image state");

  a_result_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level < aaq_pkg::LEVEL_W'(aaq_pkg::LEVELS) &&
                   out_glyph == aaq_pkg::glyph_of(out_level)))
    else $error("result glyph does not match its level");

endmodule
